FILE: rtl/i2c_rts_pkg.sv
// Package for the I2C register transaction sequencer.
// Beat types, phase and command codes, status codes and result helpers.
// No dependencies.
package i2c_rts_pkg;

    localparam logic [3:0] START_ATTEMPTS_RST = 4'd5;
    localparam logic [3:0] RECOVERY_ONES_RST  = 4'd9;
    localparam int         FIFO_DEPTH         = 4;
    localparam int         MAX_RES            = 3;

    localparam logic [1:0] OP_REQ  = 2'd0;
    localparam logic [1:0] OP_DONE = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;
    localparam logic [1:0] OP_SDA  = 2'd3;

    localparam logic [1:0] KIND_WR_REG = 2'd0;
    localparam logic [1:0] KIND_WR_RAW = 2'd1;
    localparam logic [1:0] KIND_RD_REG = 2'd2;
    localparam logic [1:0] KIND_RD_RAW = 2'd3;

    localparam logic [7:0] ST_MASK      = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_OK = 8'h18;
    localparam logic [7:0] ST_MT_DAT_OK = 8'h28;
    localparam logic [7:0] ST_MR_SLA_OK = 8'h40;
    localparam logic [7:0] ST_MR_DAT_OK = 8'h50;

    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    localparam logic       REG_IDX_ATTEMPTS = 1'b0;
    localparam logic       REG_IDX_ONES     = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_START  = 4'd1,
        CMD_SEND   = 4'd2,
        CMD_RACK   = 4'd3,
        CMD_RNACK  = 4'd4,
        CMD_STOP   = 4'd5,
        CMD_PULSE  = 4'd6,
        CMD_REINIT = 4'd7,
        CMD_NEED   = 4'd8
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START    = 4'd1,
        PH_ADDR     = 4'd2,
        PH_REG      = 4'd3,
        PH_RSTART   = 4'd4,
        PH_RADDR    = 4'd5,
        PH_NEEDDATA = 4'd6,
        PH_TX       = 4'd7,
        PH_RX       = 4'd8,
        PH_RECOVER  = 4'd9
    } t_phase;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] status;
        logic [7:0] rx_byte;
        logic [7:0] write_byte;
        logic       sda_level;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] command;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       done_res;
        logic       success;
        logic       last;
    } t_out_beat;

    function automatic t_out_beat mk_res(t_cmd cmd, logic [7:0] tx, logic rxv,
                                         logic [7:0] rxd, logic done, logic ok);
        t_out_beat r;
        r.command  = cmd;
        r.tx_byte  = tx;
        r.rx_valid = rxv;
        r.rx_data  = rxd;
        r.done_res = done;
        r.success  = ok;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic st_is(logic [7:0] status, logic [7:0] code);
        return (status & ST_MASK) == code;
    endfunction

endpackage

FILE: rtl/i2c_register_transaction_sequencer.sv
// Results of an accepted beat are registered in the queue, read from its head.
// One input beat per cycle while each gives at most one result and the output
// is not stalled; a beat gives at most two results, queued one per entry.
// Input stalls while more than one result waits in the four-entry queue.
// Reset (synchronous, active low): idle phase, queue empty, registers 5 and 9.
module i2c_register_transaction_sequencer
    import i2c_rts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_beat    i_in_beat,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_beat   o_out_beat,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [3:0] r_start_attempts;
    logic [3:0] r_recovery_ones;

    t_phase     r_phase,     n_phase;
    logic [1:0] r_txn_kind,  n_txn_kind;
    logic [7:0] r_saved_addr, n_saved_addr;
    logic [7:0] r_saved_reg, n_saved_reg;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [3:0] r_attempts,  n_attempts;
    logic [3:0] r_ones,      n_ones;

    t_out_beat  r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    t_out_beat  res [MAX_RES];
    logic [1:0] res_num;
    logic       in_fire, out_fire, sda_done;
    logic [7:0] first_addr, bl_dec;
    logic [3:0] att_inc;

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_IDX_ONES) ? {28'd0, r_recovery_ones}
                                                    : {28'd0, r_start_attempts};
    assign o_in_stall  = r_count > CNT_W'(1);
    assign o_out_valid = r_count != '0;
    assign o_out_beat  = r_fifo[r_rptr];
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_fire    = o_out_valid && !i_out_stall;

    assign first_addr = (r_txn_kind == KIND_RD_RAW) ? (r_saved_addr | ADDR_RD_BIT)
                                                    : (r_saved_addr & ADDR_WR_MASK);
    assign bl_dec     = r_bytes_left - 8'd1;
    assign att_inc    = (r_attempts < 4'd15) ? r_attempts + 4'd1 : r_attempts;

    always_comb begin
        n_phase      = r_phase;
        n_txn_kind   = r_txn_kind;
        n_saved_addr = r_saved_addr;
        n_saved_reg  = r_saved_reg;
        n_bytes_left = r_bytes_left;
        n_attempts   = r_attempts;
        n_ones       = r_ones;
        res_num      = 2'd0;
        sda_done     = 1'b0;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = mk_res(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
        end
        case (i_in_beat.op)
            OP_REQ: begin
                if (r_phase == PH_IDLE) begin
                    n_txn_kind   = i_in_beat.kind;
                    n_saved_addr = i_in_beat.dev_addr;
                    n_saved_reg  = i_in_beat.reg_addr;
                    n_bytes_left = i_in_beat.byte_count;
                    n_attempts   = 4'd0;
                    res_num      = 2'd1;
                    if (i_in_beat.byte_count == 8'd0) begin
                        res[0] = mk_res(CMD_NONE, 8'd0, 1'b0, 8'd0, 1'b1,
                                        !i_in_beat.kind[1]);
                    end else begin
                        n_phase = PH_START;
                        res[0]  = mk_res(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                    end
                end
            end
            OP_DONE: begin
                unique case (r_phase)
                    PH_START: begin
                        if (st_is(i_in_beat.status, ST_START)) begin
                            n_phase = PH_ADDR;
                            res_num = 2'd1;
                            res[0]  = mk_res(CMD_SEND, first_addr, 1'b0, 8'd0,
                                             1'b0, 1'b0);
                        end else begin
                            n_phase = PH_RECOVER;
                            n_ones  = r_recovery_ones;
                            res_num = 2'd2;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                            res[1]  = mk_res(CMD_PULSE, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end
                    end
                    PH_ADDR: begin
                        res_num = 2'd1;
                        if (!st_is(i_in_beat.status, (r_txn_kind == KIND_RD_RAW)
                                   ? ST_MR_SLA_OK : ST_MT_SLA_OK)) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
                        end else if (r_txn_kind == KIND_WR_REG ||
                                     r_txn_kind == KIND_RD_REG) begin
                            n_phase = PH_REG;
                            res[0]  = mk_res(CMD_SEND, r_saved_reg, 1'b0, 8'd0,
                                             1'b0, 1'b0);
                        end else if (r_txn_kind == KIND_WR_RAW) begin
                            n_phase = PH_NEEDDATA;
                            res[0]  = mk_res(CMD_NEED, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end else begin
                            n_phase = PH_RX;
                            res[0]  = mk_res((r_bytes_left <= 8'd1) ? CMD_RNACK
                                             : CMD_RACK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end
                    end
                    PH_REG: begin
                        res_num = 2'd1;
                        if (!st_is(i_in_beat.status, ST_MT_DAT_OK)) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
                        end else if (r_txn_kind == KIND_RD_REG) begin
                            n_phase = PH_RSTART;
                            res[0]  = mk_res(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end else begin
                            n_phase = PH_NEEDDATA;
                            res[0]  = mk_res(CMD_NEED, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end
                    end
                    PH_RSTART: begin
                        res_num = 2'd1;
                        if (!st_is(i_in_beat.status, ST_RSTART)) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
                        end else begin
                            n_phase = PH_RADDR;
                            res[0]  = mk_res(CMD_SEND, r_saved_addr | ADDR_RD_BIT,
                                             1'b0, 8'd0, 1'b0, 1'b0);
                        end
                    end
                    PH_RADDR: begin
                        res_num = 2'd1;
                        if (!st_is(i_in_beat.status, ST_MR_SLA_OK)) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
                        end else begin
                            n_phase = PH_RX;
                            res[0]  = mk_res((r_bytes_left <= 8'd1) ? CMD_RNACK
                                             : CMD_RACK, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end
                    end
                    PH_TX: begin
                        res_num = 2'd1;
                        if (!st_is(i_in_beat.status, ST_MT_DAT_OK)) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
                        end else begin
                            n_bytes_left = bl_dec;
                            if (bl_dec == 8'd0) begin
                                n_phase = PH_IDLE;
                                res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0,
                                                 1'b1, 1'b1);
                            end else begin
                                n_phase = PH_NEEDDATA;
                                res[0]  = mk_res(CMD_NEED, 8'd0, 1'b0, 8'd0,
                                                 1'b0, 1'b0);
                            end
                        end
                    end
                    PH_RX: begin
                        res_num = 2'd1;
                        if (r_bytes_left <= 8'd1) begin
                            n_bytes_left = 8'd0;
                            n_phase      = PH_IDLE;
                            res[0]       = mk_res(CMD_STOP, 8'd0, 1'b1,
                                                  i_in_beat.rx_byte, 1'b1, 1'b1);
                        end else if (!st_is(i_in_beat.status, ST_MR_DAT_OK)) begin
                            n_phase = PH_IDLE;
                            res[0]  = mk_res(CMD_STOP, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0);
                        end else begin
                            n_bytes_left = bl_dec;
                            res[0]       = mk_res((bl_dec <= 8'd1) ? CMD_RNACK
                                                  : CMD_RACK, 8'd0, 1'b1,
                                                  i_in_beat.rx_byte, 1'b0, 1'b0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            OP_DATA: begin
                if (r_phase == PH_NEEDDATA) begin
                    n_phase = PH_TX;
                    res_num = 2'd1;
                    res[0]  = mk_res(CMD_SEND, i_in_beat.write_byte, 1'b0, 8'd0,
                                     1'b0, 1'b0);
                end
            end
            default: begin
                if (r_phase == PH_RECOVER) begin
                    if (i_in_beat.sda_level) begin
                        if (r_ones <= 4'd1) begin
                            sda_done = 1'b1;
                        end else begin
                            n_ones = r_ones - 4'd1;
                        end
                    end else begin
                        n_ones = r_recovery_ones;
                    end
                    if (!sda_done) begin
                        res_num = 2'd1;
                        res[0]  = mk_res(CMD_PULSE, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                    end else begin
                        n_ones     = 4'd0;
                        n_attempts = att_inc;
                        res_num    = 2'd2;
                        res[0]     = mk_res(CMD_REINIT, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        if (att_inc < r_start_attempts) begin
                            n_phase = PH_START;
                            res[1]  = mk_res(CMD_START, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0);
                        end else begin
                            n_phase = PH_ADDR;
                            res[1]  = mk_res(CMD_SEND, first_addr, 1'b0, 8'd0,
                                             1'b0, 1'b0);
                        end
                    end
                end
            end
        endcase
        for (int k = 0; k < MAX_RES; k++) begin
            res[k].last = (2'(k) + 2'd1) == res_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_attempts <= START_ATTEMPTS_RST;
            r_recovery_ones  <= RECOVERY_ONES_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_IDX_ONES) begin
                r_recovery_ones <= pwdata[3:0];
            end else begin
                r_start_attempts <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_txn_kind   <= 2'd0;
            r_saved_addr <= 8'd0;
            r_saved_reg  <= 8'd0;
            r_bytes_left <= 8'd0;
            r_attempts   <= 4'd0;
            r_ones       <= 4'd0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_txn_kind   <= n_txn_kind;
            r_saved_addr <= n_saved_addr;
            r_saved_reg  <= n_saved_reg;
            r_bytes_left <= n_bytes_left;
            r_attempts   <= n_attempts;
            r_ones       <= n_ones;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < res_num) begin
                    r_fifo[r_wptr + PTR_W'(k)] <= res[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (in_fire) begin
                r_wptr <= r_wptr + PTR_W'(res_num);
            end
            if (out_fire) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_count <= r_count + (in_fire ? CNT_W'(res_num) : CNT_W'(0))
                               - (out_fire ? CNT_W'(1) : CNT_W'(0));
        end
    end

endmodule

FILE: rtl/i2c_rts_checker.sv
// Port-level checker for the I2C register transaction sequencer.
// Uses i2c_rts_pkg; bound to the top level at the end of this file.
module i2c_rts_checker
    import i2c_rts_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input t_out_beat   o_out_beat,
    input logic        i_out_stall,
    input logic        pready
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("queue not empty after reset");

    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind i2c_register_transaction_sequencer i2c_rts_checker u_i2c_rts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_beat  (o_out_beat),
    .i_out_stall (i_out_stall),
    .pready      (pready)
);

FILE: sim/tb.sv
// Self-checking testbench for i2c_register_transaction_sequencer: directed and random beats,
// checked against a built-in model of the transaction sequencer, with random stalls on both sides.
// Depends on rtl/i2c_rts_pkg.sv and rtl/i2c_register_transaction_sequencer.sv.
module tb;
    import i2c_rts_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_beat    in_beat   = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_beat   out_beat;
    logic        out_stall = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // sequencer model state and register copies
    t_phase      seq_ph    = PH_IDLE;
    logic [1:0]  seq_kind  = '0;
    logic [7:0]  seq_addr  = '0;
    logic [7:0]  seq_reg   = '0;
    logic [7:0]  seq_left  = '0;
    logic [3:0]  seq_tries = '0;
    logic [3:0]  seq_ones  = '0;
    logic [3:0]  cfg_tries = START_ATTEMPTS_RST;
    logic [3:0]  cfg_ones  = RECOVERY_ONES_RST;

    t_out_beat   step_res [3];
    int          step_n;
    t_out_beat   expected_cmds [$];

    int errors          = 0;
    int results_checked = 0;
    int beats_sent      = 0;
    int settings_used   = 0;
    int idle_cycles     = 0;
    int hold_req        = 0;
    bit gaps_on         = 1'b1;
    bit stall_on        = 1'b1;

    i2c_register_transaction_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic void add_res(input t_cmd c, input logic [7:0] tx, input logic rxv,
                                    input logic [7:0] rxd, input logic dn, input logic ok);
        step_res[step_n].command  = c;
        step_res[step_n].tx_byte  = tx;
        step_res[step_n].rx_valid = rxv;
        step_res[step_n].rx_data  = rxd;
        step_res[step_n].done_res = dn;
        step_res[step_n].success  = ok;
        step_res[step_n].last     = 1'b0;
        step_n++;
    endfunction

    function automatic void close_txn(input logic ok);
        seq_ph = PH_IDLE;
        add_res(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b1, ok);
    endfunction

    function automatic void ask_byte();
        seq_ph = PH_RX;
        add_res(seq_left <= 8'd1 ? CMD_RNACK : CMD_RACK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    endfunction

    function automatic logic [7:0] addr_byte_first();
        return (seq_kind == KIND_RD_RAW) ? (seq_addr | ADDR_RD_BIT) : (seq_addr & ADDR_WR_MASK);
    endfunction

    function automatic logic status_ok(input logic [7:0] s, input logic [7:0] code);
        return (s & ST_MASK) == code;
    endfunction

    task automatic advance_sequencer(input t_in_beat b);
        logic ones_done;
        step_n = 0;
        case (b.op)
            OP_REQ: begin
                if (seq_ph == PH_IDLE) begin
                    seq_kind  = b.kind;
                    seq_addr  = b.dev_addr;
                    seq_reg   = b.reg_addr;
                    seq_left  = b.byte_count;
                    seq_tries = '0;
                    if (b.byte_count == 8'd0) begin
                        add_res(CMD_NONE, 8'h00, 1'b0, 8'h00, 1'b1,
                                b.kind == KIND_WR_REG || b.kind == KIND_WR_RAW);
                    end else begin
                        seq_ph = PH_START;
                        add_res(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                    end
                end
            end
            OP_DONE: begin
                case (seq_ph)
                    PH_START: begin
                        if (status_ok(b.status, ST_START)) begin
                            seq_ph = PH_ADDR;
                            add_res(CMD_SEND, addr_byte_first(), 1'b0, 8'h00, 1'b0, 1'b0);
                        end else begin
                            seq_ph   = PH_RECOVER;
                            seq_ones = cfg_ones;
                            add_res(CMD_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                            add_res(CMD_PULSE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                        end
                    end
                    PH_ADDR: begin
                        if (!status_ok(b.status,
                                       seq_kind == KIND_RD_RAW ? ST_MR_SLA_OK : ST_MT_SLA_OK)) begin
                            close_txn(1'b0);
                        end else if (seq_kind == KIND_WR_REG || seq_kind == KIND_RD_REG) begin
                            seq_ph = PH_REG;
                            add_res(CMD_SEND, seq_reg, 1'b0, 8'h00, 1'b0, 1'b0);
                        end else if (seq_kind == KIND_WR_RAW) begin
                            seq_ph = PH_NEEDDATA;
                            add_res(CMD_NEED, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                        end else begin
                            ask_byte();
                        end
                    end
                    PH_REG: begin
                        if (!status_ok(b.status, ST_MT_DAT_OK)) begin
                            close_txn(1'b0);
                        end else if (seq_kind == KIND_RD_REG) begin
                            seq_ph = PH_RSTART;
                            add_res(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                        end else begin
                            seq_ph = PH_NEEDDATA;
                            add_res(CMD_NEED, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                        end
                    end
                    PH_RSTART: begin
                        if (!status_ok(b.status, ST_RSTART)) begin
                            close_txn(1'b0);
                        end else begin
                            seq_ph = PH_RADDR;
                            add_res(CMD_SEND, seq_addr | ADDR_RD_BIT, 1'b0, 8'h00, 1'b0, 1'b0);
                        end
                    end
                    PH_RADDR: begin
                        if (!status_ok(b.status, ST_MR_SLA_OK)) close_txn(1'b0);
                        else ask_byte();
                    end
                    PH_TX: begin
                        if (!status_ok(b.status, ST_MT_DAT_OK)) begin
                            close_txn(1'b0);
                        end else begin
                            seq_left = seq_left - 8'd1;
                            if (seq_left == 8'd0) begin
                                close_txn(1'b1);
                            end else begin
                                seq_ph = PH_NEEDDATA;
                                add_res(CMD_NEED, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                            end
                        end
                    end
                    PH_RX: begin
                        // final byte is NACKed and taken without a status check
                        if (seq_left <= 8'd1) begin
                            seq_left = '0;
                            seq_ph   = PH_IDLE;
                            add_res(CMD_STOP, 8'h00, 1'b1, b.rx_byte, 1'b1, 1'b1);
                        end else if (!status_ok(b.status, ST_MR_DAT_OK)) begin
                            close_txn(1'b0);
                        end else begin
                            seq_left = seq_left - 8'd1;
                            add_res(seq_left <= 8'd1 ? CMD_RNACK : CMD_RACK, 8'h00, 1'b1,
                                    b.rx_byte, 1'b0, 1'b0);
                        end
                    end
                    default: ;
                endcase
            end
            OP_DATA: begin
                if (seq_ph == PH_NEEDDATA) begin
                    seq_ph = PH_TX;
                    add_res(CMD_SEND, b.write_byte, 1'b0, 8'h00, 1'b0, 1'b0);
                end
            end
            default: begin
                if (seq_ph == PH_RECOVER) begin
                    ones_done = 1'b0;
                    if (b.sda_level) begin
                        if (seq_ones <= 4'd1) ones_done = 1'b1;
                        else seq_ones = seq_ones - 4'd1;
                    end else begin
                        seq_ones = cfg_ones;
                    end
                    if (!ones_done) begin
                        add_res(CMD_PULSE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                    end else begin
                        seq_ones = '0;
                        add_res(CMD_REINIT, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                        if (seq_tries < 4'd15) seq_tries = seq_tries + 4'd1;
                        if (seq_tries < cfg_tries) begin
                            seq_ph = PH_START;
                            add_res(CMD_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                        end else begin
                            // attempts used up: address goes out without a fresh START
                            seq_ph = PH_ADDR;
                            add_res(CMD_SEND, addr_byte_first(), 1'b0, 8'h00, 1'b0, 1'b0);
                        end
                    end
                end
            end
        endcase
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) expected_cmds.push_back(step_res[i]);
    endtask

    function automatic t_in_beat rand_in(input logic [1:0] op);
        logic [63:0] raw;
        t_in_beat    b;
        raw  = {$urandom, $urandom};
        b    = raw[$bits(t_in_beat)-1:0];
        b.op = op;
        return b;
    endfunction

    function automatic logic [7:0] pick_status(input logic [7:0] code, input int pct);
        logic [7:0] s;
        s = 8'($urandom);
        if ($urandom_range(0, 99) < pct) begin
            if ((s & ST_MASK) == code) s = s ^ 8'h80;
        end else begin
            s = code | (s & ~ST_MASK);
        end
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_beat(input t_in_beat b);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge i_clk); while (in_stall);
        beats_sent++;
        advance_sequencer(b);
    endtask

    task automatic send_req(input logic [1:0] kind, input logic [7:0] dev, input logic [7:0] rg,
                            input logic [7:0] cnt);
        t_in_beat b;
        b = rand_in(OP_REQ);
        b.kind       = kind;
        b.dev_addr   = dev;
        b.reg_addr   = rg;
        b.byte_count = cnt;
        send_beat(b);
    endtask

    task automatic send_done(input logic [7:0] st, input logic [7:0] rxb);
        t_in_beat b;
        b = rand_in(OP_DONE);
        b.status  = st;
        b.rx_byte = rxb;
        send_beat(b);
    endtask

    task automatic send_data(input logic [7:0] wb);
        t_in_beat b;
        b = rand_in(OP_DATA);
        b.write_byte = wb;
        send_beat(b);
    endtask

    task automatic send_sda(input logic lvl);
        t_in_beat b;
        b = rand_in(OP_SDA);
        b.sda_level = lvl;
        send_beat(b);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic [3:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_IDX_ATTEMPTS) cfg_tries = val;
        else cfg_ones = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {28'd0, val}) begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, idx, val, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [3:0] tries, input logic [3:0] ones);
        drain_results();
        write_config(REG_IDX_ATTEMPTS, tries);
        write_config(REG_IDX_ONES, ones);
        settings_used++;
    endtask

    task automatic respond(input int pct);
        case (seq_ph)
            PH_START:  send_done(pick_status(ST_START, pct), 8'($urandom));
            PH_ADDR:   send_done(pick_status(seq_kind == KIND_RD_RAW ? ST_MR_SLA_OK : ST_MT_SLA_OK,
                                             pct), 8'($urandom));
            PH_REG,
            PH_TX:     send_done(pick_status(ST_MT_DAT_OK, pct), 8'($urandom));
            PH_RSTART: send_done(pick_status(ST_RSTART, pct), 8'($urandom));
            PH_RADDR:  send_done(pick_status(ST_MR_SLA_OK, pct), 8'($urandom));
            PH_RX:     send_done(pick_status(ST_MR_DAT_OK, pct), 8'($urandom));
            PH_NEEDDATA: send_data(8'($urandom));
            default:   send_sda($urandom_range(0, 9) != 0);
        endcase
    endtask

    task automatic random_txn(input int fail_pct);
        logic [7:0] cnt;
        int         pct;
        int         sel;
        pct = fail_pct;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            cnt = 8'd0;
        end else if (sel < 80) begin
            cnt = 8'($urandom_range(1, 4));
        end else if (sel < 92) begin
            cnt = 8'($urandom_range(5, 16));
        end else begin
            // long transfers are cut short by frequent bad status
            cnt = 8'($urandom_range(17, 255));
            pct = 50;
        end
        if ($urandom_range(0, 9) == 0) send_beat(rand_in(2'($urandom_range(1, 3))));
        send_req(2'($urandom), 8'($urandom), 8'($urandom), cnt);
        while (seq_ph != PH_IDLE) begin
            if ($urandom_range(0, 99) < 6) send_beat(rand_in(2'($urandom)));
            else respond(pct);
        end
    endtask

    task automatic run_random(input int n_beats, input int fail_pct);
        int stop_at;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) random_txn(fail_pct);
    endtask

    task automatic test_zero_length;
        for (int k = 0; k < 4; k++) send_req(2'(k), 8'($urandom), 8'($urandom), 8'd0);
    endtask

    task automatic test_write_register;
        send_req(KIND_WR_REG, 8'hFF, 8'hFF, 8'd1);
        send_done(ST_START | 8'h07, 8'h00);
        send_done(ST_MT_SLA_OK, 8'hFF);
        send_done(ST_MT_DAT_OK, 8'h00);
        send_data(8'hFF);
        send_done(ST_MT_DAT_OK | 8'h07, 8'h00);
    endtask

    task automatic test_read_raw;
        send_req(KIND_RD_RAW, 8'h00, 8'h00, 8'd2);
        send_done(ST_START, 8'h00);
        send_done(ST_MR_SLA_OK, 8'h00);
        send_req(KIND_WR_RAW, 8'hFF, 8'hFF, 8'hFF);
        send_data(8'hA5);
        send_done(ST_MR_DAT_OK, 8'hFF);
        send_done(8'hFF, 8'h00);
    endtask

    task automatic test_ignored_beats;
        send_done(ST_START, 8'h5A);
        send_sda(1'b1);
    endtask

    task automatic test_exhausted_attempts;
        reconfigure(4'd1, 4'd2);
        send_req(KIND_WR_RAW, 8'($urandom), 8'($urandom), 8'd3);
        send_done(8'h20, 8'h00);
        send_sda(1'b1);
        send_sda(1'b0);
        send_sda(1'b1);
        send_sda(1'b1);
        send_done(8'h20, 8'h00);
    endtask

    task automatic test_random_reset_values;
        reconfigure(START_ATTEMPTS_RST, RECOVERY_ONES_RST);
        run_random(65, 8);
    endtask

    task automatic test_random_max_config;
        reconfigure(4'd15, 4'd15);
        run_random(55, 12);
    endtask

    task automatic test_random_min_config;
        reconfigure(4'd1, 4'd1);
        run_random(55, 15);
    endtask

    task automatic test_backpressure;
        reconfigure(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
        gaps_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        run_random(45, 8);
        gaps_on  = 1'b1;
    endtask

    task automatic test_quiet_finish;
        reconfigure(4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        run_random(55, 8);
    endtask

    initial begin : receiver_stall
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                out_stall <= 1'b1;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
                out_stall <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t: result beat, expected none, actual %h", $time, out_beat);
                errors++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("command", 8'(want.command), 8'(out_beat.command));
                check_field("tx_byte", want.tx_byte, out_beat.tx_byte);
                check_field("rx_valid", 8'(want.rx_valid), 8'(out_beat.rx_valid));
                check_field("rx_data", want.rx_data, out_beat.rx_data);
                check_field("done_res", 8'(want.done_res), 8'(out_beat.done_res));
                check_field("success", 8'(want.success), 8'(out_beat.success));
                check_field("last", 8'(want.last), 8'(out_beat.last));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat moved for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_cmds.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_length();
        test_write_register();
        test_read_raw();
        test_ignored_beats();
        test_exhausted_attempts();
        test_random_reset_values();
        test_random_max_config();
        test_random_min_config();
        test_backpressure();
        test_quiet_finish();
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d beats over %0d register settings; %0d result beats checked.",
                 beats_sent, settings_used, results_checked);
        $display("All four kinds, zero length, bad status, bus recovery and back-pressure ran.");
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
